// ----- src/ctrl_rle_pkg.sv -----
`timescale 1ns / 1ps

package ctrl_rle_pkg;

  localparam logic [2:0] OP_LOAD       = 3'd0;
  localparam logic [2:0] OP_REC_START  = 3'd1;
  localparam logic [2:0] OP_REC        = 3'd2;
  localparam logic [2:0] OP_PLAY_START = 3'd3;
  localparam logic [2:0] OP_TICK       = 3'd4;

  localparam logic [31:0] SAMPLE_MASK = 32'hFF00_FFFF;
  localparam logic [31:0] COUNT_ONE   = 32'h0001_0000;
  localparam logic [7:0]  COUNT_MAX   = 8'hFF;

  typedef enum logic [2:0] {
    KIND_LOAD,
    KIND_REC_START,
    KIND_REC,
    KIND_PLAY_START,
    KIND_TICK,
    KIND_NOP
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [11:0] slot;
    logic [31:0] data;
    logic [7:0]  sx;
    logic [7:0]  sy;
    logic [3:0]  buttons;
    logic        halt;
  } cmd_t;

  // Coded word for a sample: sticks in the low half, buttons on top, count zero.
  function automatic logic [31:0] pack_sample(input cmd_t c);
    return {c.buttons, 4'b0000, 8'h00, c.sy, c.sx};
  endfunction

endpackage

// ----- src/ctrl_rle_front.sv -----
`timescale 1ns / 1ps

module ctrl_rle_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [2:0]          op_i,
  input  logic [11:0]         slot_i,
  input  logic [31:0]         load_data_i,
  input  logic signed [7:0]   stick_x_i,
  input  logic signed [7:0]   stick_y_i,
  input  logic [3:0]          buttons_in_i,
  input  logic                halt_i,
  output logic                busy_o,
  output logic                cmd_valid_o,
  output ctrl_rle_pkg::cmd_t  cmd_o,
  input  logic                cmd_pop_i
);

  ctrl_rle_pkg::cmd_t entry_q [2];
  ctrl_rle_pkg::cmd_t cmd_in;
  logic [1:0]         count_q, count_d;
  logic               wr_ptr_q, rd_ptr_q;
  logic               push, pop;

  always_comb begin
    cmd_in.slot    = slot_i;
    cmd_in.data    = load_data_i;
    cmd_in.sx      = stick_x_i;
    cmd_in.sy      = stick_y_i;
    cmd_in.buttons = buttons_in_i;
    cmd_in.halt    = halt_i;
    case (op_i)
      ctrl_rle_pkg::OP_LOAD:       cmd_in.kind = ctrl_rle_pkg::KIND_LOAD;
      ctrl_rle_pkg::OP_REC_START:  cmd_in.kind = ctrl_rle_pkg::KIND_REC_START;
      ctrl_rle_pkg::OP_REC:        cmd_in.kind = ctrl_rle_pkg::KIND_REC;
      ctrl_rle_pkg::OP_PLAY_START: cmd_in.kind = ctrl_rle_pkg::KIND_PLAY_START;
      ctrl_rle_pkg::OP_TICK:       cmd_in.kind = ctrl_rle_pkg::KIND_TICK;
      default:                     cmd_in.kind = ctrl_rle_pkg::KIND_NOP;
    endcase
  end

  assign busy_o      = (count_q == 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];
  assign push        = start_i && !busy_o;
  assign pop         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    case ({push, pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ----- src/ctrl_rle_back.sv -----
`timescale 1ns / 1ps

module ctrl_rle_back #(
  parameter int unsigned StoreDepth = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  ctrl_rle_pkg::cmd_t  cmd_i,
  output logic                cmd_pop_o,
  output logic                result_valid_o,
  output logic signed [7:0]   play_x_o,
  output logic signed [7:0]   play_y_o,
  output logic [3:0]          held_o,
  output logic [3:0]          pressed_o,
  output logic [3:0]          released_o,
  output logic                replay_done_o,
  output logic                record_stopped_o,
  output logic [11:0]         last_slot_o
);

  localparam int unsigned AW = $clog2(StoreDepth);
  localparam logic [AW:0]   DEPTH_IDX = (AW+1)'(StoreDepth);
  localparam logic [AW-1:0] LAST_IDX  = AW'(StoreDepth - 1);

  typedef enum logic {ST_IDLE, ST_EXEC} state_e;

  state_e             state_q, state_d;
  ctrl_rle_pkg::cmd_t cmd_q, cmd_d;
  logic [AW-1:0]      rec_idx_q, rec_idx_d;
  logic               rec_empty_q, rec_empty_d;
  logic               stopped_q, stopped_d;
  logic [AW:0]        ri_q, ri_d;
  logic [7:0]         hold_q, hold_d;
  logic [3:0]         prev_q, prev_d;
  logic               res_valid_q, res_valid_d;
  logic [7:0]         px_q, px_d, py_q, py_d;
  logic [3:0]         held_q, held_d, pr_q, pr_d, rl_q, rl_d;

  logic [31:0]        mem_q [StoreDepth];
  logic [31:0]        rd_a_q, rd_b_q;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr, raddr_a, raddr_b;
  logic [31:0]        mem_wdata;

  logic [AW:0]        ri_next;
  logic [31:0]        sample_exec;
  logic [3:0]         word_held;
  logic [31:0]        rec_idx_ext;

  assign ri_next     = ri_q + (AW+1)'(1);
  assign sample_exec = ctrl_rle_pkg::pack_sample(cmd_q);
  assign word_held   = rd_a_q[31:28];

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    rec_idx_d   = rec_idx_q;
    rec_empty_d = rec_empty_q;
    stopped_d   = stopped_q;
    ri_d        = ri_q;
    hold_d      = hold_q;
    prev_d      = prev_q;
    res_valid_d = 1'b0;
    px_d        = 8'h00;
    py_d        = 8'h00;
    held_d      = 4'h0;
    pr_d        = 4'h0;
    rl_d        = 4'h0;
    cmd_pop_o   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = rec_idx_q;
    mem_wdata   = ctrl_rle_pkg::pack_sample(cmd_i);
    raddr_a     = '0;
    raddr_b     = '0;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          case (cmd_i.kind)
            ctrl_rle_pkg::KIND_LOAD: begin
              if (32'(cmd_i.slot) < StoreDepth) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(cmd_i.slot);
                mem_wdata = cmd_i.data;
              end
              res_valid_d = 1'b1;
            end
            ctrl_rle_pkg::KIND_REC_START: begin
              rec_idx_d   = '0;
              rec_empty_d = 1'b1;
              stopped_d   = 1'b0;
              res_valid_d = 1'b1;
            end
            ctrl_rle_pkg::KIND_REC: begin
              if (cmd_i.halt) begin
                stopped_d   = 1'b1;
                res_valid_d = 1'b1;
              end else if (rec_empty_q) begin
                // The first sample after start record goes in as it is.
                mem_we      = 1'b1;
                rec_empty_d = 1'b0;
                res_valid_d = 1'b1;
              end else begin
                raddr_a = rec_idx_q;
                state_d = ST_EXEC;
              end
            end
            ctrl_rle_pkg::KIND_PLAY_START: begin
              raddr_a = '0;
              state_d = ST_EXEC;
            end
            ctrl_rle_pkg::KIND_TICK: begin
              if (ri_q >= DEPTH_IDX) begin
                held_d      = prev_q;
                res_valid_d = 1'b1;
              end else begin
                // Fetch the current word and the following one together.
                raddr_a = ri_q[AW-1:0];
                raddr_b = ri_next[AW-1:0];
                state_d = ST_EXEC;
              end
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end

      ST_EXEC: begin
        state_d     = ST_IDLE;
        res_valid_d = 1'b1;
        case (cmd_q.kind)
          ctrl_rle_pkg::KIND_REC: begin
            if (((rd_a_q & ctrl_rle_pkg::SAMPLE_MASK) == sample_exec) &&
                (rd_a_q[23:16] != ctrl_rle_pkg::COUNT_MAX)) begin
              mem_we    = 1'b1;
              mem_waddr = rec_idx_q;
              mem_wdata = rd_a_q + ctrl_rle_pkg::COUNT_ONE;
            end else if (rec_idx_q == LAST_IDX) begin
              stopped_d = 1'b1;
            end else begin
              rec_idx_d = rec_idx_q + AW'(1);
              mem_we    = 1'b1;
              mem_waddr = rec_idx_q + AW'(1);
              mem_wdata = sample_exec;
            end
          end
          ctrl_rle_pkg::KIND_PLAY_START: begin
            ri_d   = '0;
            hold_d = rd_a_q[23:16];
          end
          ctrl_rle_pkg::KIND_TICK: begin
            px_d   = rd_a_q[7:0];
            py_d   = rd_a_q[15:8];
            held_d = word_held;
            pr_d   = word_held & ~prev_q;
            rl_d   = prev_q & ~word_held;
            prev_d = word_held;
            if (hold_q == 8'h00) begin
              ri_d   = ri_next;
              // Past the last word the hold count reads as zero.
              hold_d = (ri_next < DEPTH_IDX) ? rd_b_q[23:16] : 8'h00;
            end else begin
              hold_d = hold_q - 8'h01;
            end
          end
          default: begin
          end
        endcase
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= '0;
      rec_idx_q   <= '0;
      rec_empty_q <= 1'b1;
      stopped_q   <= 1'b0;
      ri_q        <= DEPTH_IDX;
      hold_q      <= 8'h00;
      prev_q      <= 4'h0;
      res_valid_q <= 1'b0;
      px_q        <= 8'h00;
      py_q        <= 8'h00;
      held_q      <= 4'h0;
      pr_q        <= 4'h0;
      rl_q        <= 4'h0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      rec_idx_q   <= rec_idx_d;
      rec_empty_q <= rec_empty_d;
      stopped_q   <= stopped_d;
      ri_q        <= ri_d;
      hold_q      <= hold_d;
      prev_q      <= prev_d;
      res_valid_q <= res_valid_d;
      px_q        <= px_d;
      py_q        <= py_d;
      held_q      <= held_d;
      pr_q        <= pr_d;
      rl_q        <= rl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_a_q <= mem_q[raddr_a];
    rd_b_q <= mem_q[raddr_b];
  end

  assign rec_idx_ext = 32'(rec_idx_q);

  assign result_valid_o   = res_valid_q;
  assign play_x_o         = px_q;
  assign play_y_o         = py_q;
  assign held_o           = held_q;
  assign pressed_o        = pr_q;
  assign released_o       = rl_q;
  assign replay_done_o    = (ri_q >= DEPTH_IDX);
  assign record_stopped_o = stopped_q;
  assign last_slot_o      = rec_idx_ext[11:0];

endmodule

// ----- src/controller_input_rle_record_replay.sv -----
`timescale 1ns / 1ps

// Run-length coded recorder and replayer for controller samples.
// Commands enter on start_i while busy_o is low; op_i selects load word,
// start record, record sample, start replay or replay tick. Every accepted
// item gives exactly one result, shown for one cycle with result_valid_o high;
// the receiver cannot stall, and results come out in the order of the items.
// A two-entry queue sits between the command front end and the executing
// back end, so up to two items may wait while one is carried out.
// Load word, start record, a halted or first sample, a tick past the end and
// an unknown op finish in the idle state; record sample, start replay and a
// replay tick go on to the execute state, set by the registered read of the
// word store (a tick reads the current word and the next hold count on two
// read ports at once). New items may queue while the back end is busy.
// Status outputs show the state after the latest result.
// After reset the store contents are undefined until written, replay reports
// done, the recorder is empty at word zero and the stopped flag is clear.
module controller_input_rle_record_replay #(
  parameter int unsigned STORE_DEPTH = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [2:0]        op_i,
  input  logic [11:0]       slot_i,
  input  logic [31:0]       load_data_i,
  input  logic signed [7:0] stick_x_i,
  input  logic signed [7:0] stick_y_i,
  input  logic [3:0]        buttons_in_i,
  input  logic              halt_i,
  output logic              result_valid_o,
  output logic signed [7:0] play_x_o,
  output logic signed [7:0] play_y_o,
  output logic [3:0]        held_o,
  output logic [3:0]        pressed_o,
  output logic [3:0]        released_o,
  output logic              replay_done_o,
  output logic              record_stopped_o,
  output logic [11:0]       last_slot_o
);

  ctrl_rle_pkg::cmd_t cmd;
  logic               cmd_valid;
  logic               cmd_pop;

  ctrl_rle_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .op_i         (op_i),
    .slot_i       (slot_i),
    .load_data_i  (load_data_i),
    .stick_x_i    (stick_x_i),
    .stick_y_i    (stick_y_i),
    .buttons_in_i (buttons_in_i),
    .halt_i       (halt_i),
    .busy_o       (busy_o),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  ctrl_rle_back #(
    .StoreDepth (STORE_DEPTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (cmd_valid),
    .cmd_i            (cmd),
    .cmd_pop_o        (cmd_pop),
    .result_valid_o   (result_valid_o),
    .play_x_o         (play_x_o),
    .play_y_o         (play_y_o),
    .held_o           (held_o),
    .pressed_o        (pressed_o),
    .released_o       (released_o),
    .replay_done_o    (replay_done_o),
    .record_stopped_o (record_stopped_o),
    .last_slot_o      (last_slot_o)
  );

`ifndef SYNTHESIS
  // A button cannot be both pressed and released on the same tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ((pressed_o & released_o) == 4'h0))
    else $error("pressed and released overlap");

  // A newly pressed button must be shown as held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ((pressed_o & ~held_o) == 4'h0))
    else $error("pressed button not held");

  // The back end drains a full queue; the queue never stays stuck full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && $past(busy_o)) |=> !busy_o)
    else $error("command queue stuck full");
`endif

endmodule
